// ----- rtl/core/otrs_pkg.sv -----
package otrs_pkg;

  localparam int WORD_BITS  = 16;
  localparam int RECV_W     = $clog2(WORD_BITS + 1);
  localparam int SEND_W     = 4;
  localparam int TEMP_W     = 8;
  // whole degrees come from word bits [7:1]
  localparam int DEG_W      = TEMP_W - 1;
  localparam int LINES      = 2;

  localparam logic [7:0] BYTE_SKIP_ROM = 8'hCC;
  localparam logic [7:0] BYTE_CONVERT  = 8'h44;
  localparam logic [7:0] BYTE_READ_SP  = 8'hBE;
  localparam logic [TEMP_W-1:0] TEMP_ERR = 8'hFF;

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RESET1    = 4'd1,
    PH_PRESENCE1 = 4'd2,
    PH_SKIP1     = 4'd3,
    PH_CONVERT   = 4'd4,
    PH_POLL      = 4'd5,
    PH_RESET2    = 4'd6,
    PH_PRESENCE2 = 4'd7,
    PH_SKIP2     = 4'd8,
    PH_READ_SP   = 4'd9,
    PH_RECV      = 4'd10,
    PH_OK        = 4'd11,
    PH_ERR       = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_RESET    = 3'd1,
    ACT_PRESENCE = 3'd2,
    ACT_WRITE    = 3'd3,
    ACT_READ     = 3'd4,
    ACT_RELEASE  = 3'd5
  } act_t;

  typedef struct packed {
    phase_t                    status;
    act_t                      bus_action;
    logic                      write_value;
    logic signed [TEMP_W-1:0]  temperature;
  } result_t;

endpackage

// ----- rtl/core/otrs_seq.sv -----
module otrs_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic                   command,
  input  logic [1:0]             sensor_select,
  input  logic [1:0]             line_sample,
  output otrs_pkg::result_t      res
);
  import otrs_pkg::*;

  phase_t                    phase, phase_next;
  logic [SEND_W-1:0]         send_cnt, send_cnt_next;
  logic [RECV_W-1:0]         recv_cnt, recv_cnt_next;
  logic [DEG_W-1:0]          shift [LINES];
  logic [DEG_W-1:0]          shift_next [LINES];
  logic [DEG_W-1:0]          stored [LINES];
  logic [DEG_W-1:0]          stored_next [LINES];
  logic [7:0]                cur_byte;
  logic [2:0]                bit_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      send_cnt <= '0;
      recv_cnt <= '0;
      for (int i = 0; i < LINES; i++) begin
        shift[i]  <= '0;
        stored[i] <= '0;
      end
    end else if (fire) begin
      phase    <= phase_next;
      send_cnt <= send_cnt_next;
      recv_cnt <= recv_cnt_next;
      for (int i = 0; i < LINES; i++) begin
        shift[i]  <= shift_next[i];
        stored[i] <= stored_next[i];
      end
    end
  end

  always_comb begin
    case (phase)
      PH_CONVERT: cur_byte = BYTE_CONVERT;
      PH_READ_SP: cur_byte = BYTE_READ_SP;
      default:    cur_byte = BYTE_SKIP_ROM;
    endcase
  end

  // bit slot 1..7 of the word lands at degree bit 0..6
  assign bit_pos = recv_cnt[2:0] - 3'd1;

  always_comb begin
    phase_next    = phase;
    send_cnt_next = send_cnt;
    recv_cnt_next = recv_cnt;
    for (int i = 0; i < LINES; i++) begin
      shift_next[i]  = shift[i];
      stored_next[i] = stored[i];
    end
    res.status      = phase;
    res.bus_action  = ACT_NONE;
    res.write_value = 1'b0;
    res.temperature = '0;

    if (command == CMD_MEASURE) begin
      case (phase)
        PH_IDLE, PH_RESET1: begin
          res.bus_action = ACT_RESET;
          phase_next     = PH_PRESENCE1;
        end
        PH_RESET2: begin
          res.bus_action = ACT_RESET;
          phase_next     = PH_PRESENCE2;
        end
        PH_PRESENCE1, PH_PRESENCE2: begin
          res.bus_action = ACT_PRESENCE;
          if (line_sample != 2'b00) begin
            phase_next = PH_ERR;
          end else if (phase == PH_PRESENCE1) begin
            phase_next = PH_SKIP1;
          end else begin
            phase_next = PH_SKIP2;
          end
        end
        PH_SKIP1, PH_CONVERT, PH_SKIP2, PH_READ_SP: begin
          if (send_cnt < SEND_W'(8)) begin
            res.bus_action  = ACT_WRITE;
            res.write_value = cur_byte[send_cnt[2:0]];
            send_cnt_next   = send_cnt + SEND_W'(1);
          end else begin
            res.bus_action = ACT_RELEASE;
            send_cnt_next  = '0;
            phase_next     = phase_t'(phase + 4'd1);
          end
        end
        PH_POLL: begin
          res.bus_action = ACT_READ;
          if (line_sample[0]) begin
            phase_next = PH_RESET2;
          end
        end
        PH_RECV: begin
          if (recv_cnt < RECV_W'(WORD_BITS)) begin
            res.bus_action = ACT_READ;
            recv_cnt_next  = recv_cnt + RECV_W'(1);
            for (int i = 0; i < LINES; i++) begin
              if (recv_cnt == '0) begin
                shift_next[i] = '0;
              end else if (recv_cnt < RECV_W'(TEMP_W)) begin
                shift_next[i][bit_pos] = line_sample[i];
              end
            end
          end else begin
            recv_cnt_next = '0;
            phase_next    = PH_OK;
            for (int i = 0; i < LINES; i++) begin
              stored_next[i] = shift[i];
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      if (sensor_select[1] == 1'b0) begin
        if (phase == PH_ERR) begin
          phase_next      = PH_IDLE;
          res.temperature = TEMP_ERR;
        end else begin
          if (phase == PH_OK) begin
            phase_next = PH_IDLE;
          end
          res.temperature = {1'b0, stored[sensor_select[0]]};
        end
      end
    end
    res.status = phase_next;
  end

endmodule

// ----- rtl/core/onewire_temp_read_sequencer_unit.sv -----
// Channel | Handshake           | Payload
// in      | in_valid / in_stall | command, sensor_select, line_sample
// out     | out_valid/out_stall | status, bus_action, write_value, temperature
//
// One transaction per cycle sustained while the result is not stalled; a transaction
// passes the input register, then the sequencer step into the result register.
// Synchronous active-high rst returns the sequence to idle and clears counters,
// shift words and stored readings.
// A stalled result holds; the input register keeps taking a transaction while
// the result register is free or is being drained the same cycle.
module onewire_temp_read_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [1:0]                    sensor_select,
  input  logic [1:0]                    line_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    status,
  output logic [2:0]                    bus_action,
  output logic                          write_value,
  output logic signed [otrs_pkg::TEMP_W-1:0] temperature
);
  import otrs_pkg::*;

  logic        s1_valid;
  logic        s1_command;
  logic [1:0]  s1_sel;
  logic [1:0]  s1_lines;
  logic        advance;
  logic        fire;
  logic        in_take;
  result_t     step_res;
  result_t     out_res;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command <= command;
      s1_sel     <= sensor_select;
      s1_lines   <= line_sample;
    end
    if (fire) begin
      out_res <= step_res;
    end
  end

  otrs_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .command       (s1_command),
    .sensor_select (s1_sel),
    .line_sample   (s1_lines),
    .res           (step_res)
  );

  assign status      = out_res.status;
  assign bus_action  = out_res.bus_action;
  assign write_value = out_res.write_value;
  assign temperature = out_res.temperature;

endmodule

// ----- rtl/core/otrs_checker.sv -----
module otrs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [3:0]                    status,
  input logic [2:0]                    bus_action,
  input logic                          write_value,
  input logic signed [otrs_pkg::TEMP_W-1:0] temperature
);
  import otrs_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(bus_action)
      && $stable(write_value) && $stable(temperature))
    else $error("stalled result changed");

  a_wv_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_value |-> bus_action == ACT_WRITE)
    else $error("write_value set outside a write slot");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_action == ACT_WRITE |->
      status == PH_SKIP1 || status == PH_CONVERT || status == PH_SKIP2
      || status == PH_READ_SP)
    else $error("write slot outside a command byte phase");

  a_reset_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_action == ACT_RESET |->
      status == PH_PRESENCE1 || status == PH_PRESENCE2)
    else $error("bus reset not followed by presence phase");

  a_temp_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && temperature != '0 |-> bus_action == ACT_NONE)
    else $error("temperature reported with a bus action");

endmodule

bind onewire_temp_read_sequencer_unit otrs_checker u_otrs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .bus_action  (bus_action),
  .write_value (write_value),
  .temperature (temperature)
);
